@@ rtl/core/art_pkg.sv @@
// Shared types and constants for the address region table.
// Holds the action codes, the stored entry layout and the controller/datapath interface.
// No dependencies.
package art_pkg;

    localparam int ADDR_W    = 32;
    localparam int KIND_W    = 4;
    localparam int PERM_W    = 8;
    localparam int CNT_OUT_W = 4;

    // Configuration register indexes.
    localparam logic REG_END_LIMIT = 1'b0;
    localparam logic REG_HEAP_KIND = 1'b1;

    localparam logic [ADDR_W-1:0] END_LIMIT_RST = 32'hFFFF_E000;
    localparam logic [KIND_W-1:0] HEAP_KIND_RST = 4'd0;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_FIND   = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_RESIZE = 3'd3,
        ACT_QUERY  = 3'd4,
        ACT_CLEAR  = 3'd5
    } t_action;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [KIND_W-1:0] kind;
        logic [PERM_W-1:0] perm;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;        // capture the input item
        logic scan_clr;   // clear all scan results
        logic ovl_clr;    // clear the overlap flag only
        logic scan_rd;    // read one entry for the scan
        logic pass2;      // this scan read checks the resized range
        logic mv;         // move one entry (read now, write next cycle)
        logic wr_new;     // write the added entry
        logic wr_resize;  // write the matched entry with its new end
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic res_load;   // load the result register
        logic res_ok;
        logic res_report; // result carries the matched entry
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action act;
        logic    hit;
        logic    ovl;
        logic    ins_found;
        logic    add_ok;
        logic    rsz_ok;
    } t_dp_sts;

endpackage

@@ rtl/core/art_dp.sv @@
// Datapath of the address region table: entry memory, scan compare logic,
// entry count and result register. Depends on art_pkg.
module art_dp #(
    parameter int MAX_REGIONS = 8,
    parameter int PAGE_SHIFT  = 12,
    parameter int IW          = $clog2(MAX_REGIONS),
    parameter int CW          = $clog2(MAX_REGIONS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  art_pkg::t_dp_cmd                i_cmd,
    input  logic [IW-1:0]                   i_rd_addr,
    input  logic [IW-1:0]                   i_wr_addr,
    input  logic [2:0]                      i_action,
    input  logic [art_pkg::ADDR_W-1:0]      i_range_start,
    input  logic [art_pkg::ADDR_W-1:0]      i_range_end,
    input  logic [art_pkg::KIND_W-1:0]      i_region_kind,
    input  logic [art_pkg::PERM_W-1:0]      i_access_bits,
    input  logic [art_pkg::ADDR_W-1:0]      i_probe_address,
    input  logic [art_pkg::ADDR_W-1:0]      i_resized_end,
    input  logic [art_pkg::ADDR_W-1:0]      i_end_limit,
    input  logic [art_pkg::KIND_W-1:0]      i_heap_kind,
    output art_pkg::t_dp_sts                o_sts,
    output logic [IW-1:0]                   o_hit_idx,
    output logic [IW-1:0]                   o_ins_idx,
    output logic [CW-1:0]                   o_count,
    output logic                            o_status,
    output logic [art_pkg::ADDR_W-1:0]      o_found_start,
    output logic [art_pkg::ADDR_W-1:0]      o_found_end,
    output logic [art_pkg::ADDR_W-1:0]      o_found_size,
    output logic [art_pkg::KIND_W-1:0]      o_found_kind,
    output logic [art_pkg::PERM_W-1:0]      o_found_access,
    output logic [art_pkg::CNT_OUT_W-1:0]   o_entry_count
);

    localparam logic [art_pkg::ADDR_W-1:0] PMASK =
        art_pkg::ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

    art_pkg::t_entry r_mem [MAX_REGIONS];
    art_pkg::t_entry r_rd_data;

    art_pkg::t_action               r_act;
    logic [art_pkg::ADDR_W-1:0]     r_rs;
    logic [art_pkg::ADDR_W-1:0]     r_re;
    logic [art_pkg::KIND_W-1:0]     r_kind;
    logic [art_pkg::PERM_W-1:0]     r_perm;
    logic [art_pkg::ADDR_W-1:0]     r_probe;
    logic [art_pkg::ADDR_W-1:0]     r_ne;

    logic            r_sv;
    logic            r_sp2;
    logic [IW-1:0]   r_sidx;
    logic            r_mv_we;
    logic [IW-1:0]   r_mv_wa;

    logic            r_hit;
    logic [IW-1:0]   r_hit_idx;
    art_pkg::t_entry r_hit_e;
    logic            r_ovl;
    logic            r_ins_found;
    logic [IW-1:0]   r_ins_idx;
    logic [CW-1:0]   r_count;

    logic                           r_status;
    logic [art_pkg::ADDR_W-1:0]     r_f_start;
    logic [art_pkg::ADDR_W-1:0]     r_f_end;
    logic [art_pkg::ADDR_W-1:0]     r_f_size;
    logic [art_pkg::KIND_W-1:0]     r_f_kind;
    logic [art_pkg::PERM_W-1:0]     r_f_perm;
    logic [art_pkg::CNT_OUT_W-1:0]  r_f_count;

    art_pkg::t_entry scan_e;
    logic            match;
    logic            add_ovl;
    logic            rsz_ovl;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    art_pkg::t_entry mem_wd;

    // Scan comparisons on the entry read in the previous cycle.
    always_comb begin
        scan_e  = r_rd_data;
        match   = (r_act == art_pkg::ACT_FIND) ?
                  (r_probe >= scan_e.start_addr && r_probe < scan_e.end_addr) :
                  (scan_e.kind == r_kind);
        add_ovl = !(r_re <= scan_e.start_addr || r_rs >= scan_e.end_addr);
        rsz_ovl = (r_sidx != r_hit_idx) &&
                  !(r_ne <= scan_e.start_addr || r_hit_e.start_addr >= scan_e.end_addr);
    end

    // One write port, shared by entry moves, insertion and resize.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = i_wr_addr;
        mem_wd = r_rd_data;
        if (r_mv_we) begin
            mem_we = 1'b1;
            mem_wa = r_mv_wa;
        end else if (i_cmd.wr_new) begin
            mem_we = 1'b1;
            mem_wd = '{start_addr: r_rs, end_addr: r_re, kind: r_kind, perm: r_perm};
        end else if (i_cmd.wr_resize) begin
            mem_we = 1'b1;
            mem_wd = '{start_addr: r_hit_e.start_addr, end_addr: r_ne,
                       kind: r_hit_e.kind, perm: r_hit_e.perm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.scan_rd || i_cmd.mv) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        r_mv_wa <= i_wr_addr;
        r_sidx  <= i_rd_addr;
        r_sp2   <= i_cmd.pass2;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_act   <= art_pkg::t_action'(i_action);
            r_rs    <= i_range_start;
            r_re    <= i_range_end;
            r_kind  <= i_region_kind;
            r_perm  <= i_access_bits;
            r_probe <= i_probe_address;
            r_ne    <= i_resized_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv        <= 1'b0;
            r_mv_we     <= 1'b0;
            r_hit       <= 1'b0;
            r_ovl       <= 1'b0;
            r_ins_found <= 1'b0;
            r_count     <= '0;
        end else begin
            r_sv    <= i_cmd.scan_rd;
            r_mv_we <= i_cmd.mv;
            if (i_cmd.scan_clr) begin
                r_hit       <= 1'b0;
                r_ovl       <= 1'b0;
                r_ins_found <= 1'b0;
            end else if (i_cmd.ovl_clr) begin
                r_ovl <= 1'b0;
            end else if (r_sv) begin
                if (!r_sp2) begin
                    if (match && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (add_ovl) begin
                        r_ovl <= 1'b1;
                    end
                    if (r_rs < scan_e.start_addr && !r_ins_found) begin
                        r_ins_found <= 1'b1;
                    end
                end else if (rsz_ovl) begin
                    r_ovl <= 1'b1;
                end
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Index and copy of the first matching entry and the first later start.
    always_ff @(posedge i_clk) begin
        if (r_sv && !r_sp2) begin
            if (match && !r_hit) begin
                r_hit_idx <= r_sidx;
                r_hit_e   <= scan_e;
            end
            if (r_rs < scan_e.start_addr && !r_ins_found) begin
                r_ins_idx <= r_sidx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status  <= !i_cmd.res_ok;
            r_f_count <= art_pkg::CNT_OUT_W'(r_count);
            if (i_cmd.res_report) begin
                r_f_start <= r_hit_e.start_addr;
                r_f_end   <= r_hit_e.end_addr;
                r_f_size  <= r_hit_e.end_addr - r_hit_e.start_addr;
                r_f_kind  <= r_hit_e.kind;
                r_f_perm  <= r_hit_e.perm;
            end else begin
                r_f_start <= '0;
                r_f_end   <= '0;
                r_f_size  <= '0;
                r_f_kind  <= '0;
                r_f_perm  <= '0;
            end
        end
    end

    always_comb begin
        o_sts.act       = r_act;
        o_sts.hit       = r_hit;
        o_sts.ovl       = r_ovl;
        o_sts.ins_found = r_ins_found;
        o_sts.add_ok    = ((r_rs & PMASK) == '0) &&
                          (r_kind == i_heap_kind || (r_re & PMASK) == '0) &&
                          (r_re >= r_rs) && (r_re <= i_end_limit) &&
                          (r_count < MAX_CNT);
        o_sts.rsz_ok    = (r_ne <= i_end_limit) && (r_ne >= r_hit_e.start_addr);
    end

    assign o_hit_idx      = r_hit_idx;
    assign o_ins_idx      = r_ins_idx;
    assign o_count        = r_count;
    assign o_status       = r_status;
    assign o_found_start  = r_f_start;
    assign o_found_end    = r_f_end;
    assign o_found_size   = r_f_size;
    assign o_found_kind   = r_f_kind;
    assign o_found_access = r_f_perm;
    assign o_entry_count  = r_f_count;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mv_we |-> !(i_cmd.wr_new || i_cmd.wr_resize))
        else $error("entry move collides with another memory write");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("entry count exceeds table depth");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> (CW'(i_rd_addr) < r_count))
        else $error("scan reads an entry beyond the held count");

endmodule

@@ rtl/core/art_ctrl.sv @@
// Controller of the address region table: sequences scans, entry shifts and writes
// for one action at a time and owns the result handshake. Depends on art_pkg.
module art_ctrl #(
    parameter int MAX_REGIONS = 8,
    parameter int IW          = $clog2(MAX_REGIONS),
    parameter int CW          = $clog2(MAX_REGIONS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    input  art_pkg::t_dp_sts  i_sts,
    input  logic [IW-1:0]     i_hit_idx,
    input  logic [IW-1:0]     i_ins_idx,
    input  logic [CW-1:0]     i_count,
    output art_pkg::t_dp_cmd  o_cmd,
    output logic [IW-1:0]     o_rd_addr,
    output logic [IW-1:0]     o_wr_addr
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SCAN2,
        S_RSZ_WR,
        S_SHIFT,
        S_WRITE,
        S_RESULT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_ins, n_ins;
    logic          r_ok, n_ok;
    logic          r_report, n_report;
    logic          r_out_valid, n_out_valid;

    logic [CW-1:0] idx_m1;
    logic [CW-1:0] idx_p1;

    always_comb begin
        idx_m1      = r_idx - 1'b1;
        idx_p1      = r_idx + 1'b1;
        n_state     = r_state;
        n_idx       = r_idx;
        n_ins       = r_ins;
        n_ok        = r_ok;
        n_report    = r_report;
        o_cmd       = '0;
        o_rd_addr   = r_idx[IW-1:0];
        o_wr_addr   = r_idx[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.cap      = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_idx          = '0;
                    n_ok           = 1'b0;
                    n_report       = 1'b0;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN, S_SCAN2: begin
                // The last read is evaluated at the edge that leaves this state.
                if (r_idx < i_count) begin
                    o_cmd.scan_rd = 1'b1;
                    o_cmd.pass2   = (r_state == S_SCAN2);
                    n_idx         = idx_p1;
                end else begin
                    n_state = (r_state == S_SCAN) ? S_DECIDE : S_RSZ_WR;
                end
            end
            S_DECIDE: begin
                n_state = S_RESULT;
                case (i_sts.act)
                    art_pkg::ACT_ADD: begin
                        if (i_sts.add_ok && !i_sts.hit && !i_sts.ovl) begin
                            n_ins   = i_sts.ins_found ? CW'(i_ins_idx) : i_count;
                            n_idx   = i_count;
                            n_state = S_SHIFT;
                        end
                    end
                    art_pkg::ACT_REMOVE: begin
                        if (i_sts.hit) begin
                            n_ok     = 1'b1;
                            n_report = 1'b1;
                            n_idx    = CW'(i_hit_idx);
                            n_state  = S_SHIFT;
                        end
                    end
                    art_pkg::ACT_FIND, art_pkg::ACT_QUERY: begin
                        n_ok     = i_sts.hit;
                        n_report = i_sts.hit;
                    end
                    art_pkg::ACT_RESIZE: begin
                        if (i_sts.hit && i_sts.rsz_ok) begin
                            o_cmd.ovl_clr = 1'b1;
                            n_idx         = '0;
                            n_state       = S_SCAN2;
                        end
                    end
                    art_pkg::ACT_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_ok          = 1'b1;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            S_RSZ_WR: begin
                if (!i_sts.ovl) begin
                    o_cmd.wr_resize = 1'b1;
                    o_wr_addr       = i_hit_idx;
                    n_ok            = 1'b1;
                end
                n_state = S_RESULT;
            end
            S_SHIFT: begin
                // Each move reads one entry here and writes it one place over in the next cycle.
                if (i_sts.act == art_pkg::ACT_ADD) begin
                    if (r_idx > r_ins) begin
                        o_cmd.mv  = 1'b1;
                        o_rd_addr = idx_m1[IW-1:0];
                        o_wr_addr = r_idx[IW-1:0];
                        n_idx     = idx_m1;
                    end else begin
                        n_state = S_WRITE;
                    end
                end else begin
                    if (idx_p1 < i_count) begin
                        o_cmd.mv  = 1'b1;
                        o_rd_addr = idx_p1[IW-1:0];
                        o_wr_addr = r_idx[IW-1:0];
                        n_idx     = idx_p1;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = S_RESULT;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.wr_new  = 1'b1;
                o_wr_addr     = r_ins[IW-1:0];
                o_cmd.cnt_inc = 1'b1;
                n_ok          = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_ok     = r_ok;
                    o_cmd.res_report = r_report;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_ins       <= '0;
            r_ok        <= 1'b0;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_ins       <= n_ins;
            r_ok        <= n_ok;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && i_sts.act == art_pkg::ACT_ADD) |-> (r_idx >= r_ins))
        else $error("insertion shift passed the insert position");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SCAN2) |-> (r_idx <= i_count))
        else $error("scan index ran past the entry count");

endmodule

@@ rtl/core/address_region_table_core.sv @@
// Address region table: a sorted table of address ranges managed by one action per item.
// Top level: stream ports, configuration registers and the controller/datapath pair.
// Depends on art_pkg, art_ctrl and art_dp.
//
// An item enters on the s_axis channel with its action in tuser and operands in tdata;
// every item gives exactly one result on the m_axis channel. Items are worked one at a
// time: s_axis_tready is high only while no item is in progress.
// Each action scans the held entries through one memory read port, one entry a cycle.
// Find, query, clear and actions rejected after the first scan then go straight to the result.
// An add shifts the entries from its insert position up by one place and then writes the
// new entry; a remove shifts the entries behind the hit down by one place. Each shift
// moves one entry a cycle; a resize that passes its checks scans the entries again first.
// The next item can be accepted in the cycle after the result is loaded.
// A finished result waits in an output register, so the next item is accepted while
// the receiver stalls; a further result waits in the controller until it is taken.
// The configuration port writes end_limit at address 0 and heap_type_code at 4; it
// must be written only while the table is idle. Reset empties the table and sets
// end_limit to 0xFFFFE000 and heap_type_code to 0; entry storage is not cleared.
module address_region_table_core #(
    parameter int MAX_REGIONS = 8,
    parameter int PAGE_SHIFT  = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // range_start[31:0], range_end[63:32], region_kind[67:64], access_bits[75:68],
    // probe_address[107:76], resized_end[139:108], zero fill[143:140]
    input  logic [143:0]  s_axis_tdata,
    // action[2:0]
    input  logic [2:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // found_start[31:0], found_end[63:32], found_size[95:64], found_kind[99:96],
    // found_access[107:100], entry_count[111:108]
    output logic [111:0]  m_axis_tdata,
    // status[0]
    output logic [0:0]    m_axis_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    logic [art_pkg::ADDR_W-1:0] r_end_limit;
    logic [art_pkg::KIND_W-1:0] r_heap_kind;
    logic                       reg_idx;

    art_pkg::t_dp_cmd cmd;
    art_pkg::t_dp_sts sts;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    wr_addr;
    logic [IW-1:0]    hit_idx;
    logic [IW-1:0]    ins_idx;
    logic [CW-1:0]    count;

    logic                              res_status;
    logic [art_pkg::ADDR_W-1:0]        res_start;
    logic [art_pkg::ADDR_W-1:0]        res_end;
    logic [art_pkg::ADDR_W-1:0]        res_size;
    logic [art_pkg::KIND_W-1:0]        res_kind;
    logic [art_pkg::PERM_W-1:0]        res_perm;
    logic [art_pkg::CNT_OUT_W-1:0]     res_count;

    // Registers sit on word addresses; the low address bits are ignored.
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_limit <= art_pkg::END_LIMIT_RST;
            r_heap_kind <= art_pkg::HEAP_KIND_RST;
        end else if (psel && penable && pwrite) begin
            if (reg_idx == art_pkg::REG_END_LIMIT) begin
                r_end_limit <= pwdata;
            end else begin
                r_heap_kind <= pwdata[art_pkg::KIND_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == art_pkg::REG_HEAP_KIND) begin
            prdata = {{(32 - art_pkg::KIND_W){1'b0}}, r_heap_kind};
        end else begin
            prdata = r_end_limit;
        end
    end

    art_ctrl #(
        .MAX_REGIONS (MAX_REGIONS),
        .IW          (IW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (sts),
        .i_hit_idx (hit_idx),
        .i_ins_idx (ins_idx),
        .i_count   (count),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr)
    );

    art_dp #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .IW          (IW),
        .CW          (CW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rd_addr       (rd_addr),
        .i_wr_addr       (wr_addr),
        .i_action        (s_axis_tuser),
        .i_range_start   (s_axis_tdata[31:0]),
        .i_range_end     (s_axis_tdata[63:32]),
        .i_region_kind   (s_axis_tdata[67:64]),
        .i_access_bits   (s_axis_tdata[75:68]),
        .i_probe_address (s_axis_tdata[107:76]),
        .i_resized_end   (s_axis_tdata[139:108]),
        .i_end_limit     (r_end_limit),
        .i_heap_kind     (r_heap_kind),
        .o_sts           (sts),
        .o_hit_idx       (hit_idx),
        .o_ins_idx       (ins_idx),
        .o_count         (count),
        .o_status        (res_status),
        .o_found_start   (res_start),
        .o_found_end     (res_end),
        .o_found_size    (res_size),
        .o_found_kind    (res_kind),
        .o_found_access  (res_perm),
        .o_entry_count   (res_count)
    );

    assign m_axis_tdata = {res_count, res_perm, res_kind, res_size, res_end, res_start};
    assign m_axis_tuser = res_status;

endmodule
